// ----- src/swa_pkg.sv -----
// Shared constants for the sliding window assigner.
`timescale 1ns / 1ps
package swa_pkg;

    localparam int DEFAULT_MAX_WINDOWS = 64;
    localparam int DEFAULT_TIME_BITS   = 47;

    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_ADDR_BITS = 2;
    localparam int SLIDE_BITS    = 20;
    localparam int LENGTH_BITS   = 20;
    localparam int COUNT_BITS    = 7;

    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SLIDE         = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_COUNT  = 2'd2;

endpackage

// ----- src/sliding_window_assigner_unit.sv -----
// Sliding window assigner: restoring divider followed by a window emit sequencer.
// After a request is taken, the divider resolves quotient and remainder bit by bit,
// a prep step forms the newest window start, then one window per cycle is emitted,
// newest first, up to the configured count or slot zero. A new request is taken only when idle,
// once the one-bit-per-cycle divider and the one-window-per-cycle emitter have finished.
// Results are strobed for one cycle; the receiver cannot stall. Reset clears the
// sequencer and sets window_length, slide and window_count to 1.
`timescale 1ns / 1ps
module sliding_window_assigner_unit
    import swa_pkg::*;
#(
    parameter int MAX_WINDOWS = DEFAULT_MAX_WINDOWS,
    parameter int TIME_BITS   = DEFAULT_TIME_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [TIME_BITS-1:0]     event_time,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                     result_valid,
    output logic [TIME_BITS-1:0]     window_start,
    output logic [TIME_BITS:0]       window_end,
    output logic [TIME_BITS-1:0]     slot_index,
    output logic                     is_last
);

    localparam int END_BITS   = TIME_BITS + 1;
    localparam int SUB_BITS   = (TIME_BITS > SLIDE_BITS) ? TIME_BITS : SLIDE_BITS;
    localparam int DIV_CNT_W  = $clog2(TIME_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [SLIDE_BITS-1:0]  slide_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [DIV_CNT_W-1:0]   bit_cnt_reg;
    logic [COUNT_BITS-1:0]  left_reg;
    logic                   valid_reg;

    logic [TIME_BITS-1:0]   time_reg;
    logic [TIME_BITS-1:0]   quo_reg;
    logic [SLIDE_BITS-1:0]  rem_reg;
    logic [TIME_BITS-1:0]   ws_reg;
    logic [TIME_BITS-1:0]   start_out_reg;
    logic [END_BITS-1:0]    end_out_reg;
    logic [TIME_BITS-1:0]   slot_out_reg;
    logic                   last_out_reg;

    logic [SLIDE_BITS-1:0]  slide_eff;
    logic [COUNT_BITS-1:0]  count_eff;
    logic [SLIDE_BITS:0]    rem_shift;
    logic [SLIDE_BITS:0]    trial;
    logic [SLIDE_BITS-1:0]  rem_next;
    logic [TIME_BITS-1:0]   quo_shift_next;
    logic [SUB_BITS-1:0]    base_diff;
    logic                   emit_last;
    logic                   accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign slide_eff = (slide_reg == '0) ? SLIDE_BITS'(1) : slide_reg;
    assign count_eff = (count_reg > COUNT_BITS'(MAX_WINDOWS)) ?
                       COUNT_BITS'(MAX_WINDOWS) : count_reg;

    // One restoring division step: shift in the next dividend bit, try the subtract.
    assign rem_shift = {rem_reg, quo_reg[TIME_BITS-1]};
    assign trial     = rem_shift - {1'b0, slide_eff};
    always_comb
    begin
        if (!trial[SLIDE_BITS])
        begin
            rem_next       = trial[SLIDE_BITS-1:0];
            quo_shift_next = {quo_reg[TIME_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next       = rem_shift[SLIDE_BITS-1:0];
            quo_shift_next = {quo_reg[TIME_BITS-2:0], 1'b0};
        end
    end

    // Newest window start: timestamp minus remainder.
    assign base_diff = SUB_BITS'(time_reg) - SUB_BITS'(rem_reg);

    // Stop at the count or when the slot reaches zero.
    assign emit_last = (left_reg == COUNT_BITS'(1)) || (quo_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_cnt_reg == DIV_CNT_W'(1))
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (count_eff == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            length_reg  <= LENGTH_BITS'(1);
            slide_reg   <= SLIDE_BITS'(1);
            count_reg   <= COUNT_BITS'(1);
            bit_cnt_reg <= '0;
            left_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == ST_EMIT);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: length_reg <= cfg_data[LENGTH_BITS-1:0];
                    REG_SLIDE:         slide_reg  <= cfg_data[SLIDE_BITS-1:0];
                    REG_WINDOW_COUNT:  count_reg  <= cfg_data[COUNT_BITS-1:0];
                    default:           ;
                endcase
            end
            if (accept)
                bit_cnt_reg <= DIV_CNT_W'(TIME_BITS);
            else if (state_reg == ST_DIV)
                bit_cnt_reg <= bit_cnt_reg - DIV_CNT_W'(1);
            if (state_reg == ST_PREP)
                left_reg <= count_eff;
            else if (state_reg == ST_EMIT)
                left_reg <= left_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg <= event_time;
            quo_reg  <= event_time;
            rem_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= quo_shift_next;
            rem_reg <= rem_next;
        end
        else if (state_reg == ST_EMIT)
        begin
            // advance one slide back
            quo_reg <= quo_reg - TIME_BITS'(1);
        end

        if (state_reg == ST_PREP)
            ws_reg <= base_diff[TIME_BITS-1:0];
        else if (state_reg == ST_EMIT)
            ws_reg <= ws_reg - TIME_BITS'(slide_eff);

        if (state_reg == ST_EMIT)
        begin
            start_out_reg <= ws_reg;
            end_out_reg   <= END_BITS'(ws_reg) + END_BITS'(length_reg);
            slot_out_reg  <= quo_reg;
            last_out_reg  <= emit_last;
        end
    end

    assign result_valid = valid_reg;
    assign window_start = start_out_reg;
    assign window_end   = end_out_reg;
    assign slot_index   = slot_out_reg;
    assign is_last      = last_out_reg;

endmodule
